// File: rtl/indexed_integer_fetch_and_op_store_macros.svh
// ----------------------------------------------------------------------------
// Indexed integer fetch-and-op store: assertion macros
// Concurrent checks that vanish in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef INDEXED_INTEGER_FETCH_AND_OP_STORE_MACROS_SVH
`define INDEXED_INTEGER_FETCH_AND_OP_STORE_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define IIFOS_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define IIFOS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define IIFOS_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`define IIFOS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: rtl/iifos_pkg.sv
// ----------------------------------------------------------------------------
// iifos_pkg
// Shared types, codes and request decode for the fetch-and-op store.
// ----------------------------------------------------------------------------
package iifos_pkg;

    localparam int DATA_W    = 32;
    localparam int CNT_W     = $clog2(DATA_W);
    localparam int DEPTH_DEF = 64;

    // request kinds
    localparam logic [2:0] KIND_CLEAR   = 3'd0;
    localparam logic [2:0] KIND_GET     = 3'd1;
    localparam logic [2:0] KIND_SWAP    = 3'd2;
    localparam logic [2:0] KIND_INC     = 3'd3;
    localparam logic [2:0] KIND_DEC     = 3'd4;
    localparam logic [2:0] KIND_OPERATE = 3'd5;

    // operator codes for operate
    localparam logic [4:0] OP_SET     = 5'd0;
    localparam logic [4:0] OP_ADD_EQ  = 5'd1;
    localparam logic [4:0] OP_SUB_EQ  = 5'd2;
    localparam logic [4:0] OP_MUL_EQ  = 5'd3;
    localparam logic [4:0] OP_DIV_EQ  = 5'd4;
    localparam logic [4:0] OP_POST_INC = 5'd5;
    localparam logic [4:0] OP_POST_DEC = 5'd6;
    localparam logic [4:0] OP_AND_EQ  = 5'd7;
    localparam logic [4:0] OP_OR_EQ   = 5'd8;
    localparam logic [4:0] OP_XOR_EQ  = 5'd9;
    localparam logic [4:0] OP_SHL_EQ  = 5'd10;
    localparam logic [4:0] OP_SHR_EQ  = 5'd11;
    localparam logic [4:0] OP_ADD     = 5'd12;
    localparam logic [4:0] OP_SUB     = 5'd13;
    localparam logic [4:0] OP_MUL     = 5'd14;
    localparam logic [4:0] OP_DIV     = 5'd15;
    localparam logic [4:0] OP_AND     = 5'd16;
    localparam logic [4:0] OP_OR      = 5'd17;
    localparam logic [4:0] OP_XOR     = 5'd18;
    localparam logic [4:0] OP_SHL     = 5'd19;
    localparam logic [4:0] OP_SHR     = 5'd20;

    // shared unit operations
    localparam logic [3:0] ALU_ADD   = 4'd0;
    localparam logic [3:0] ALU_SUB   = 4'd1;
    localparam logic [3:0] ALU_MUL   = 4'd2;
    localparam logic [3:0] ALU_DIV   = 4'd3;
    localparam logic [3:0] ALU_AND   = 4'd4;
    localparam logic [3:0] ALU_OR    = 4'd5;
    localparam logic [3:0] ALU_XOR   = 4'd6;
    localparam logic [3:0] ALU_SHL   = 4'd7;
    localparam logic [3:0] ALU_SHR   = 4'd8;
    localparam logic [3:0] ALU_PASSB = 4'd9;

    localparam logic signed [DATA_W-1:0] FAIL_VALUE = -32'sd1;

    typedef struct packed {
        logic [2:0]               kind;
        logic signed [15:0]       index;
        logic [4:0]               op_code;
        logic signed [DATA_W-1:0] operand;
    } t_req;

    typedef struct packed {
        logic signed [DATA_W-1:0] result_value;
        logic                     ok;
    } t_rsp;

    // what the sequencer does with one request
    typedef struct packed {
        logic [3:0] alu_op;
        logic       b_one;    // use constant one as second operand
        logic       wr;       // write unit result back to the entry
        logic       ret_old;  // answer with the entry value before the update
        logic       bad;      // unknown kind or operator
    } t_dec;

    function automatic t_dec decode(input logic [2:0] kind, input logic [4:0] code);
        t_dec d;
        d = '{alu_op: ALU_PASSB, b_one: 1'b0, wr: 1'b0, ret_old: 1'b0, bad: 1'b0};
        case (kind)
            KIND_CLEAR: begin
                d.wr = 1'b0;
            end
            KIND_GET: begin
                d.ret_old = 1'b1;
            end
            KIND_SWAP: begin
                d.wr      = 1'b1;
                d.ret_old = 1'b1;
            end
            KIND_INC: begin
                d.alu_op  = ALU_ADD;
                d.b_one   = 1'b1;
                d.wr      = 1'b1;
                d.ret_old = 1'b1;
            end
            KIND_DEC: begin
                d.alu_op  = ALU_SUB;
                d.b_one   = 1'b1;
                d.wr      = 1'b1;
                d.ret_old = 1'b1;
            end
            KIND_OPERATE: begin
                case (code)
                    OP_SET:      begin d.alu_op = ALU_PASSB; d.wr = 1'b1; end
                    OP_ADD_EQ:   begin d.alu_op = ALU_ADD;   d.wr = 1'b1; end
                    OP_SUB_EQ:   begin d.alu_op = ALU_SUB;   d.wr = 1'b1; end
                    OP_MUL_EQ:   begin d.alu_op = ALU_MUL;   d.wr = 1'b1; end
                    OP_DIV_EQ:   begin d.alu_op = ALU_DIV;   d.wr = 1'b1; end
                    OP_POST_INC: begin
                        d.alu_op  = ALU_ADD;
                        d.b_one   = 1'b1;
                        d.wr      = 1'b1;
                        d.ret_old = 1'b1;
                    end
                    OP_POST_DEC: begin
                        d.alu_op  = ALU_SUB;
                        d.b_one   = 1'b1;
                        d.wr      = 1'b1;
                        d.ret_old = 1'b1;
                    end
                    OP_AND_EQ:   begin d.alu_op = ALU_AND;   d.wr = 1'b1; end
                    OP_OR_EQ:    begin d.alu_op = ALU_OR;    d.wr = 1'b1; end
                    OP_XOR_EQ:   begin d.alu_op = ALU_XOR;   d.wr = 1'b1; end
                    OP_SHL_EQ:   begin d.alu_op = ALU_SHL;   d.wr = 1'b1; end
                    OP_SHR_EQ:   begin d.alu_op = ALU_SHR;   d.wr = 1'b1; end
                    OP_ADD:      d.alu_op = ALU_ADD;
                    OP_SUB:      d.alu_op = ALU_SUB;
                    OP_MUL:      d.alu_op = ALU_MUL;
                    OP_DIV:      d.alu_op = ALU_DIV;
                    OP_AND:      d.alu_op = ALU_AND;
                    OP_OR:       d.alu_op = ALU_OR;
                    OP_XOR:      d.alu_op = ALU_XOR;
                    OP_SHL:      d.alu_op = ALU_SHL;
                    OP_SHR:      d.alu_op = ALU_SHR;
                    default:     d.bad = 1'b1;
                endcase
            end
            default: begin
                d.bad = 1'b1;
            end
        endcase
        return d;
    endfunction

endpackage

// File: rtl/iifos_alu.sv
// ----------------------------------------------------------------------------
// iifos_alu
// Shared arithmetic unit: one adder serves add, subtract, shift-add multiply
// and restoring divide, one bit per cycle for the iterative operations.
// ----------------------------------------------------------------------------
module iifos_alu
    import iifos_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_go,
    input  logic [3:0]        i_op,
    input  logic [DATA_W-1:0] i_a,
    input  logic [DATA_W-1:0] i_b,
    output logic              o_done,
    output logic [DATA_W-1:0] o_y
);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [3:0]        r_op, n_op;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [DATA_W-1:0] r_acc, n_acc;
    logic [DATA_W-1:0] r_x, n_x;      // multiplicand or partial remainder
    logic [DATA_W-1:0] r_y, n_y;      // multiplier or dividend/quotient
    logic [DATA_W-1:0] r_b, n_b;      // divisor magnitude
    logic              r_neg, n_neg;
    logic [DATA_W-1:0] r_res, n_res;

    logic [DATA_W-1:0] add_a, add_b;
    logic              add_sub;
    logic [DATA_W:0]   add_sum;
    logic [DATA_W-1:0] rem_sh;
    logic [DATA_W-1:0] a_mag, b_mag;

    assign rem_sh = {r_x[DATA_W-2:0], r_y[DATA_W-1]};
    assign a_mag  = i_a[DATA_W-1] ? (~i_a + DATA_W'(1)) : i_a;
    assign b_mag  = i_b[DATA_W-1] ? (~i_b + DATA_W'(1)) : i_b;

    // operand steering for the one adder
    always_comb begin
        if (r_busy) begin
            if (r_op == ALU_MUL) begin
                add_a   = r_acc;
                add_b   = r_x;
                add_sub = 1'b0;
            end else begin
                add_a   = rem_sh;
                add_b   = r_b;
                add_sub = 1'b1;
            end
        end else begin
            add_a   = i_a;
            add_b   = i_b;
            add_sub = (i_op == ALU_SUB);
        end
    end

    // carry out is set on subtract when add_a >= add_b
    assign add_sum = {1'b0, add_a} + {1'b0, (add_sub ? ~add_b : add_b)}
                   + {{DATA_W{1'b0}}, add_sub};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_op   = r_op;
        n_cnt  = r_cnt;
        n_acc  = r_acc;
        n_x    = r_x;
        n_y    = r_y;
        n_b    = r_b;
        n_neg  = r_neg;
        n_res  = r_res;
        if (r_busy) begin
            if (r_op == ALU_MUL) begin
                n_acc = r_y[0] ? add_sum[DATA_W-1:0] : r_acc;
                n_x   = {r_x[DATA_W-2:0], 1'b0};
                n_y   = {1'b0, r_y[DATA_W-1:1]};
            end else begin
                n_x = add_sum[DATA_W] ? add_sum[DATA_W-1:0] : rem_sh;
                n_y = {r_y[DATA_W-2:0], add_sum[DATA_W]};
            end
            n_cnt = r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(DATA_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
                if (r_op == ALU_MUL) begin
                    n_res = n_acc;
                end else begin
                    n_res = r_neg ? (~n_y + DATA_W'(1)) : n_y;
                end
            end
        end else if (i_go) begin
            n_op   = i_op;
            n_done = 1'b1;
            case (i_op)
                ALU_ADD:   n_res = add_sum[DATA_W-1:0];
                ALU_SUB:   n_res = add_sum[DATA_W-1:0];
                ALU_MUL: begin
                    n_done = 1'b0;
                    n_busy = 1'b1;
                    n_cnt  = '0;
                    n_acc  = '0;
                    n_x    = i_a;
                    n_y    = i_b;
                end
                ALU_DIV: begin
                    n_done = 1'b0;
                    n_busy = 1'b1;
                    n_cnt  = '0;
                    n_x    = '0;
                    n_y    = a_mag;
                    n_b    = b_mag;
                    n_neg  = i_a[DATA_W-1] ^ i_b[DATA_W-1];
                end
                ALU_AND:   n_res = i_a & i_b;
                ALU_OR:    n_res = i_a | i_b;
                ALU_XOR:   n_res = i_a ^ i_b;
                ALU_SHL:   n_res = i_a << i_b[CNT_W-1:0];
                ALU_SHR:   n_res = DATA_W'($signed(i_a) >>> i_b[CNT_W-1:0]);
                ALU_PASSB: n_res = i_b;
                default:   n_res = '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op  <= n_op;
        r_cnt <= n_cnt;
        r_acc <= n_acc;
        r_x   <= n_x;
        r_y   <= n_y;
        r_b   <= n_b;
        r_neg <= n_neg;
        r_res <= n_res;
    end

    assign o_done = r_done;
    assign o_y    = r_res;

endmodule

// File: rtl/indexed_integer_fetch_and_op_store.sv
// ----------------------------------------------------------------------------
// indexed_integer_fetch_and_op_store
// Table of signed 32-bit entries with get, swap, fetch-increment/decrement,
// operate and clear requests, worked through one shared arithmetic unit.
//
// Timing: a simple request passes through the read, execute and wait states;
// multiply and divide stay in wait while the shared unit runs its
// one-bit-per-cycle loop; rejected requests answer in the next cycle; clear
// writes every entry in turn, then answers. One request at a time; busy drops
// in the answer cycle, and start is ignored while busy. The receiver cannot
// stall. Reset clears the ready flag; table contents are unknown until a clear.
// ----------------------------------------------------------------------------
`include "indexed_integer_fetch_and_op_store_macros.svh"

module indexed_integer_fetch_and_op_store
    import iifos_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_req i_req,
    output logic o_rsp_strobe,
    output t_rsp o_rsp
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_READ  = 3'd1;
    localparam logic [2:0] S_EXEC  = 3'd2;
    localparam logic [2:0] S_WAIT  = 3'd3;
    localparam logic [2:0] S_CLEAR = 3'd4;

    logic [2:0]        r_state, n_state;
    logic              r_ready, n_ready;
    logic              r_strobe, n_strobe;
    t_rsp              r_rsp, n_rsp;
    t_req              r_req, n_req;
    t_dec              r_dec, n_dec;
    logic [AW-1:0]     r_addr, n_addr;
    logic [AW-1:0]     r_clr, n_clr;
    logic [DATA_W-1:0] r_rdata;

    logic [DATA_W-1:0] mem [DEPTH];

    t_dec              dec;
    logic              idx_ok;
    logic              arg_bad;
    logic              mem_we;
    logic [AW-1:0]     mem_wa;
    logic [DATA_W-1:0] mem_wd;
    logic              alu_go;
    logic [DATA_W-1:0] alu_b;
    logic              alu_done;
    logic [DATA_W-1:0] alu_y;

    // screen the incoming request before touching the table
    always_comb begin
        dec     = decode(i_req.kind, i_req.op_code);
        idx_ok  = !i_req.index[15] && (i_req.index[14:0] < 15'(DEPTH));
        arg_bad = dec.bad
               || (dec.alu_op == ALU_DIV && i_req.operand == '0)
               || ((dec.alu_op == ALU_SHL || dec.alu_op == ALU_SHR)
                   && i_req.operand[DATA_W-1:CNT_W] != '0);
    end

    assign alu_b = r_dec.b_one ? DATA_W'(1) : r_req.operand;

    iifos_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (alu_go),
        .i_op    (r_dec.alu_op),
        .i_a     (r_rdata),
        .i_b     (alu_b),
        .o_done  (alu_done),
        .o_y     (alu_y)
    );

    always_comb begin
        n_state  = r_state;
        n_ready  = r_ready;
        n_strobe = 1'b0;
        n_rsp    = r_rsp;
        n_req    = r_req;
        n_dec    = r_dec;
        n_addr   = r_addr;
        n_clr    = r_clr;
        mem_we   = 1'b0;
        mem_wa   = r_addr;
        mem_wd   = alu_y;
        alu_go   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_req  = i_req;
                    n_dec  = dec;
                    n_addr = i_req.index[AW-1:0];
                    if (i_req.kind == KIND_CLEAR) begin
                        // clear runs whatever the index or ready state
                        n_clr   = '0;
                        n_state = S_CLEAR;
                    end else if (!r_ready || !idx_ok || arg_bad) begin
                        // reject at once, table untouched
                        n_rsp    = '{result_value: FAIL_VALUE, ok: 1'b0};
                        n_strobe = 1'b1;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                // entry lands in r_rdata at the end of this cycle
                n_state = S_EXEC;
            end
            S_EXEC: begin
                alu_go  = 1'b1;
                n_state = S_WAIT;
            end
            S_WAIT: begin
                if (alu_done) begin
                    mem_we   = r_dec.wr;
                    n_rsp    = '{result_value: (r_dec.ret_old ? r_rdata : alu_y),
                                 ok: 1'b1};
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_CLEAR: begin
                mem_we = 1'b1;
                mem_wa = r_clr;
                mem_wd = '0;
                n_clr  = r_clr + AW'(1);
                if (r_clr == AW'(DEPTH - 1)) begin
                    n_ready  = 1'b1;
                    n_rsp    = '{result_value: '0, ok: 1'b1};
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // table: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rdata <= mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ready  <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ready  <= n_ready;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rsp  <= n_rsp;
        r_req  <= n_req;
        r_dec  <= n_dec;
        r_addr <= n_addr;
        r_clr  <= n_clr;
    end

    assign busy         = (r_state != S_IDLE);
    assign o_rsp_strobe = r_strobe;
    assign o_rsp        = r_rsp;

    // every answer is preceded by a start or a busy cycle
    `IIFOS_ASSERT_IMPLY(a_rsp_has_req, i_clk, i_rst_n, o_rsp_strobe, $past(busy || start), "answer without a request")
    // a successful answer implies the table has been cleared once
    `IIFOS_ASSERT_IMPLY(a_ok_needs_ready, i_clk, i_rst_n, o_rsp_strobe && o_rsp.ok, r_ready, "ok answer while table not ready")
    // the table is never written while idle
    `IIFOS_ASSERT_IMPLY(a_no_idle_write, i_clk, i_rst_n, r_state == S_IDLE, !mem_we, "table write while idle")
    // the shared unit only finishes while the sequencer waits for it
    `IIFOS_ASSERT_IMPLY(a_alu_done_in_wait, i_clk, i_rst_n, alu_done, r_state == S_WAIT, "unit result outside wait state")

endmodule
